// ===== hw/rtl/ptopo_pkg.sv =====
// Shared types and codes of the pass dependency ordering block.
package ptopo_pkg;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_RUN    = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [4:0] pass_index;
    logic [7:0] resource_key;
    logic       is_write;
    logic [5:0] pass_count;
  } item_t;

  typedef struct packed {
    logic [4:0] order_pass;
    logic       cycle_detected;
    logic       last;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_MEM,
    OP_LOAD,
    OP_REC_RD,
    OP_REC_WR,
    OP_KEY_RD,
    OP_KEY_LD,
    OP_PROD_STEP,
    OP_CONS_STEP,
    OP_KEY_NEXT,
    OP_INIT_STEP,
    OP_POP_RD,
    OP_POP_LD,
    OP_EDGE_RD,
    OP_EDGE_LD,
    OP_OUT_RD,
    OP_OUT_LD
  } op_t;

  typedef struct packed {
    logic clr_last;
    logic n_zero;
    logic masks_empty;
    logic key_last;
    logic bit_last;
    logic has_prod;
    logic fifo_empty;
    logic edges_done;
    logic out_last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/ptopo_ctrl.sv =====
// Sequencing state machine of the pass dependency ordering block.
module ptopo_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_is_run,
  output logic               item_ready,
  input  ptopo_pkg::status_t st,
  output ptopo_pkg::op_t     op
);

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_REC_RD,
    S_REC_WR,
    S_KEY_RD,
    S_KEY_LD,
    S_PROD,
    S_CONS,
    S_KEY_NEXT,
    S_INIT,
    S_POP,
    S_POP_LD,
    S_EDGE,
    S_EDGE_LD,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  state_t state;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_CLR:      op = ptopo_pkg::OP_CLR_MEM;
      S_IDLE:     op = item_valid ? ptopo_pkg::OP_LOAD : ptopo_pkg::OP_NONE;
      S_REC_RD:   op = ptopo_pkg::OP_REC_RD;
      S_REC_WR:   op = ptopo_pkg::OP_REC_WR;
      S_KEY_RD:   op = ptopo_pkg::OP_KEY_RD;
      S_KEY_LD:   op = ptopo_pkg::OP_KEY_LD;
      S_PROD:     op = ptopo_pkg::OP_PROD_STEP;
      S_CONS:     op = ptopo_pkg::OP_CONS_STEP;
      S_KEY_NEXT: op = ptopo_pkg::OP_KEY_NEXT;
      S_INIT:     op = ptopo_pkg::OP_INIT_STEP;
      S_POP:      op = st.fifo_empty ? ptopo_pkg::OP_NONE : ptopo_pkg::OP_POP_RD;
      S_POP_LD:   op = ptopo_pkg::OP_POP_LD;
      S_EDGE:     op = st.edges_done ? ptopo_pkg::OP_NONE : ptopo_pkg::OP_EDGE_RD;
      S_EDGE_LD:  op = ptopo_pkg::OP_EDGE_LD;
      S_OUT_RD:   op = ptopo_pkg::OP_OUT_RD;
      S_OUT_LD:   op = st.out_free ? ptopo_pkg::OP_OUT_LD : ptopo_pkg::OP_NONE;
      default:    op = ptopo_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      unique case (state)
        S_CLR:      if (st.clr_last) state <= S_IDLE;
        S_IDLE:     if (item_valid) state <= item_is_run ? S_KEY_RD : S_REC_RD;
        S_REC_RD:   state <= S_REC_WR;
        S_REC_WR:   state <= S_IDLE;
        S_KEY_RD:   state <= S_KEY_LD;
        S_KEY_LD:   state <= st.masks_empty ? S_KEY_NEXT : S_PROD;
        S_PROD: begin
          if (st.bit_last) state <= st.has_prod ? S_CONS : S_KEY_NEXT;
        end
        S_CONS:     if (st.bit_last) state <= S_KEY_NEXT;
        S_KEY_NEXT: begin
          if (!st.key_last) state <= S_KEY_RD;
          else state <= st.n_zero ? S_IDLE : S_INIT;
        end
        S_INIT:     if (st.bit_last) state <= S_POP;
        S_POP:      state <= st.fifo_empty ? S_OUT_RD : S_POP_LD;
        S_POP_LD:   state <= S_EDGE;
        S_EDGE:     state <= st.edges_done ? S_POP : S_EDGE_LD;
        S_EDGE_LD:  state <= S_EDGE;
        S_OUT_RD:   state <= S_OUT_LD;
        S_OUT_LD: begin
          if (st.out_free) state <= st.out_last ? S_IDLE : S_OUT_RD;
        end
        default:    state <= S_CLR;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ptopo_dp.sv =====
// Datapath of the pass dependency ordering block: access masks, edge store and queue.
module ptopo_dp #(
  parameter int MAX_PASSES = 32,
  parameter int RES_DEPTH  = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptopo_pkg::op_t       op,
  input  ptopo_pkg::item_t     item,
  output ptopo_pkg::status_t   st,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ptopo_pkg::result_t   result
);

  localparam int PW = $clog2(MAX_PASSES);
  localparam int CW = $clog2(MAX_PASSES + 1);
  localparam int AW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int LD = 1 << (2 * PW);

  ptopo_pkg::item_t item_r;
  logic [CW-1:0] n_r;
  logic [MAX_PASSES-1:0] live;

  logic [2*MAX_PASSES-1:0] mask_mem [RES_DEPTH];
  logic [2*MAX_PASSES-1:0] mem_q;
  logic [AW-1:0] ra, wa, kcnt;
  logic we;
  logic [2*MAX_PASSES-1:0] wd;
  logic rec_ok;
  logic [MAX_PASSES-1:0] pass_bit;

  logic [MAX_PASSES-1:0] prod_r, cons_r;
  logic [PW-1:0] bcnt, prev_r, lastp_r;
  logic prev_v, lastp_v;

  logic [MAX_PASSES-1:0] edge_q [MAX_PASSES];
  logic [PW-1:0] ecnt [MAX_PASSES];
  logic [PW-1:0] indeg [MAX_PASSES];
  logic link_req, do_link;
  logic [PW-1:0] link_from, link_to;

  logic [PW-1:0] list_mem [LD];
  logic [PW-1:0] list_q;
  logic [PW-1:0] order_mem [MAX_PASSES];
  logic [PW-1:0] ord_q;
  logic [CW-1:0] head, tail, ocnt;
  logic [PW-1:0] u_r, kidx;
  logic push_en;
  logic [PW-1:0] push_val;
  logic cyc;

  always_comb begin
    for (int j = 0; j < MAX_PASSES; j++) live[j] = (j < int'(n_r));
  end

  assign rec_ok   = (32'(item_r.resource_key) < 32'(RES_DEPTH)) &&
                    (32'(item_r.pass_index) < 32'(MAX_PASSES));
  assign pass_bit = MAX_PASSES'(1) << item_r.pass_index;

  always_comb begin
    ra = kcnt;
    wa = kcnt;
    we = 1'b0;
    wd = '0;
    case (op)
      ptopo_pkg::OP_REC_RD: ra = AW'(item_r.resource_key);
      ptopo_pkg::OP_REC_WR: begin
        wa = AW'(item_r.resource_key);
        we = rec_ok;
        wd = item_r.is_write ? (mem_q | {pass_bit, {MAX_PASSES{1'b0}}})
                             : (mem_q | {{MAX_PASSES{1'b0}}, pass_bit});
      end
      ptopo_pkg::OP_CLR_MEM, ptopo_pkg::OP_KEY_LD: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mask_mem[wa] <= wd;
    if (op == ptopo_pkg::OP_REC_RD || op == ptopo_pkg::OP_KEY_RD) mem_q <= mask_mem[ra];
  end

  always_comb begin
    link_req  = 1'b0;
    link_from = prev_r;
    link_to   = bcnt;
    if (op == ptopo_pkg::OP_PROD_STEP && prod_r[bcnt] && prev_v) begin
      link_req = 1'b1;
    end
    if (op == ptopo_pkg::OP_CONS_STEP && cons_r[bcnt]) begin
      link_req  = 1'b1;
      link_from = lastp_v ? lastp_r : prev_r;
    end
  end

  assign do_link = link_req && (link_from != link_to) && !edge_q[link_from][link_to];

  always_ff @(posedge clk) begin
    if (op == ptopo_pkg::OP_LOAD) begin
      for (int j = 0; j < MAX_PASSES; j++) begin
        edge_q[j] <= '0;
        ecnt[j]   <= '0;
        indeg[j]  <= '0;
      end
    end else if (do_link) begin
      edge_q[link_from][link_to] <= 1'b1;
      ecnt[link_from]            <= ecnt[link_from] + PW'(1);
      indeg[link_to]             <= indeg[link_to] + PW'(1);
    end else if (op == ptopo_pkg::OP_EDGE_LD) begin
      indeg[list_q] <= indeg[list_q] - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_link) list_mem[{link_from, ecnt[link_from]}] <= link_to;
    if (op == ptopo_pkg::OP_EDGE_RD) list_q <= list_mem[{u_r, kidx}];
  end

  always_comb begin
    push_en  = 1'b0;
    push_val = bcnt;
    if (op == ptopo_pkg::OP_INIT_STEP && indeg[bcnt] == '0) push_en = 1'b1;
    if (op == ptopo_pkg::OP_EDGE_LD && indeg[list_q] == PW'(1)) begin
      push_en  = 1'b1;
      push_val = list_q;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) order_mem[tail[PW-1:0]] <= push_val;
    if (op == ptopo_pkg::OP_POP_RD) ord_q <= order_mem[head[PW-1:0]];
    else if (op == ptopo_pkg::OP_OUT_RD) ord_q <= order_mem[ocnt[PW-1:0]];
  end

  assign cyc = (tail != n_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      kcnt    <= '0;
      n_r     <= '0;
      bcnt    <= '0;
      prev_v  <= 1'b0;
      lastp_v <= 1'b0;
      head    <= '0;
      tail    <= '0;
      ocnt    <= '0;
      kidx    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (op == ptopo_pkg::OP_OUT_LD) result_valid <= 1'b1;
      else if (result_valid && result_ready) result_valid <= 1'b0;
      if (push_en) tail <= tail + CW'(1);
      case (op)
        ptopo_pkg::OP_CLR_MEM: kcnt <= kcnt + AW'(1);
        ptopo_pkg::OP_LOAD: begin
          item_r <= item;
          n_r    <= (32'(item.pass_count) > 32'(MAX_PASSES)) ? CW'(MAX_PASSES)
                                                              : CW'(item.pass_count);
          kcnt   <= '0;
          bcnt   <= '0;
          head   <= '0;
          tail   <= '0;
          ocnt   <= '0;
        end
        ptopo_pkg::OP_KEY_LD: begin
          prod_r  <= mem_q[2*MAX_PASSES-1:MAX_PASSES] & live;
          cons_r  <= mem_q[MAX_PASSES-1:0] & live;
          bcnt    <= '0;
          prev_v  <= 1'b0;
          lastp_v <= 1'b0;
        end
        ptopo_pkg::OP_PROD_STEP: begin
          if (prod_r[bcnt]) begin
            prev_r <= bcnt;
            prev_v <= 1'b1;
          end
          bcnt <= st.bit_last ? '0 : bcnt + PW'(1);
        end
        ptopo_pkg::OP_CONS_STEP: begin
          if (prod_r[bcnt]) begin
            lastp_r <= bcnt;
            lastp_v <= 1'b1;
          end
          bcnt <= st.bit_last ? '0 : bcnt + PW'(1);
        end
        ptopo_pkg::OP_KEY_NEXT: begin
          kcnt <= kcnt + AW'(1);
          bcnt <= '0;
        end
        ptopo_pkg::OP_INIT_STEP: bcnt <= st.bit_last ? '0 : bcnt + PW'(1);
        ptopo_pkg::OP_POP_LD: begin
          u_r  <= ord_q;
          head <= head + CW'(1);
          kidx <= '0;
        end
        ptopo_pkg::OP_EDGE_LD: kidx <= kidx + PW'(1);
        ptopo_pkg::OP_OUT_LD: begin
          result.order_pass     <= cyc ? 5'(ocnt) : 5'(ord_q);
          result.cycle_detected <= cyc;
          result.last           <= st.out_last;
          ocnt <= ocnt + CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st.clr_last    = (kcnt == AW'(RES_DEPTH - 1));
    st.n_zero      = (n_r == '0);
    st.masks_empty = ~|(mem_q & {live, live});
    st.key_last    = (kcnt == AW'(RES_DEPTH - 1));
    st.bit_last    = (CW'(bcnt) + CW'(1) == n_r);
    st.has_prod    = |prod_r;
    st.fifo_empty  = (head == tail);
    st.edges_done  = (kidx == ecnt[u_r]);
    st.out_last    = (ocnt + CW'(1) == n_r);
    st.out_free    = !result_valid || result_ready;
  end

endmodule

// ===== hw/rtl/pass_dependency_topo_order_unit.sv =====
// Top level of the pass dependency ordering block.
// A record transaction sets one producer or consumer bit for a resource key
// when the key and pass index are in range. A run transaction sweeps every key
// of the access memory, scans the producer bits of each key that holds a live
// access and, when that key has a live producer, its consumer bits too, and
// clears the memory as it goes. Unless the pass count is zero it then seeds the
// ready queue, runs the queue-based ordering and hands out one result at a
// time, holding each until the consumer takes it. No new transaction is taken
// until the block is idle again. After reset the block clears the access
// memory before it takes its first transaction.
module pass_dependency_topo_order_unit #(
  parameter int MAX_PASSES = 32,
  parameter int RES_DEPTH  = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ptopo_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output ptopo_pkg::result_t result
);

  ptopo_pkg::op_t     op;
  ptopo_pkg::status_t st;

  ptopo_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_is_run (item.cmd == ptopo_pkg::CMD_RUN),
    .item_ready  (item_ready),
    .st          (st),
    .op          (op)
  );

  ptopo_dp #(
    .MAX_PASSES (MAX_PASSES),
    .RES_DEPTH  (RES_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .item         (item),
    .st           (st),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (op == ptopo_pkg::OP_OUT_LD) |-> st.out_free)
    else $error("Result register loaded while a transaction is pending.");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (op == ptopo_pkg::OP_POP_RD) |-> !st.fifo_empty)
    else $error("Ready queue popped while empty.");

  a_idle_when_busy: assert property (@(posedge clk) disable iff (rst)
    (op == ptopo_pkg::OP_EDGE_LD) |-> !item_ready)
    else $error("Input accepted during the ordering phase.");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the pass dependency ordering block.
`timescale 1ns / 1ps

module testbench;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  ptopo_pkg::item_t   item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  ptopo_pkg::result_t result;

  pass_dependency_topo_order_unit uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    ptopo_pkg::item_t   it;
    bit                 typed;
    int                 nexp;
    ptopo_pkg::result_t e0;
    ptopo_pkg::result_t e1;
  } stim_row_t;

  logic [31:0]        writer_mask[256];
  logic [31:0]        reader_mask[256];
  logic [31:0]        edge_bits[32];
  int                 successors[32][$];
  int                 pred_count[32];
  ptopo_pkg::result_t order_scratch[$];
  ptopo_pkg::result_t expected_order[$];
  bit                 failed = 1'b0;
  int                 sent_count = 0;

  function automatic void add_edge(int from, int to);
    if (from == to || edge_bits[from][to]) return;
    edge_bits[from][to] = 1'b1;
    successors[from] = {successors[from], to};
    pred_count[to]++;
  endfunction

  function automatic void predict_order(ptopo_pkg::item_t it);
    int n, prev, top, dep, u;
    logic [31:0] live, pm, cm;
    int ready_q[$];
    int sorted[$];
    bit cyc;
    ptopo_pkg::result_t r;
    order_scratch.delete();
    if (it.cmd == ptopo_pkg::CMD_RECORD) begin
      if (it.is_write) writer_mask[it.resource_key][it.pass_index] = 1'b1;
      else reader_mask[it.resource_key][it.pass_index] = 1'b1;
      return;
    end
    n = (it.pass_count > 32) ? 32 : it.pass_count;
    live = (n == 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 1);
    for (int i = 0; i < 32; i++) begin
      edge_bits[i] = '0;
      successors[i].delete();
      pred_count[i] = 0;
    end
    if (n > 0) begin
      for (int k = 0; k < 256; k++) begin
        pm = writer_mask[k] & live;
        cm = reader_mask[k] & live;
        prev = -1;
        for (int p = 0; p < n; p++) begin
          if (pm[p]) begin
            if (prev >= 0) add_edge(prev, p);
            prev = p;
          end
        end
        top = prev;
        if (top >= 0) begin
          for (int c = 0; c < n; c++) begin
            if (cm[c]) begin
              dep = -1;
              for (int b = 0; b < c; b++) if (pm[b]) dep = b;
              if (dep < 0) dep = top;
              add_edge(dep, c);
            end
          end
        end
      end
    end
    for (int k = 0; k < 256; k++) begin
      writer_mask[k] = '0;
      reader_mask[k] = '0;
    end
    if (n == 0) return;
    for (int i = 0; i < n; i++) if (pred_count[i] == 0) ready_q = {ready_q, i};
    while (ready_q.size() > 0) begin
      u = ready_q.pop_front();
      sorted = {sorted, u};
      foreach (successors[u][j]) begin
        if (pred_count[successors[u][j]] > 0) begin
          pred_count[successors[u][j]]--;
          if (pred_count[successors[u][j]] == 0) ready_q = {ready_q, successors[u][j]};
        end
      end
    end
    cyc = (sorted.size() != n);
    for (int i = 0; i < n; i++) begin
      r.order_pass = cyc ? 5'(i) : 5'(sorted[i]);
      r.cycle_detected = cyc;
      r.last = (i + 1 == n);
      order_scratch = {order_scratch, r};
    end
  endfunction

  task automatic send_item(stim_row_t row);
    bit quiet;
    quiet = (sent_count >= 150 && sent_count < 260);
    while (!quiet && $urandom_range(99) < 16) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item = row.it;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    predict_order(row.it);
    if (row.typed) begin
      if (row.nexp > 0) expected_order = {expected_order, row.e0};
      if (row.nexp > 1) expected_order = {expected_order, row.e1};
    end else begin
      foreach (order_scratch[i]) expected_order = {expected_order, order_scratch[i]};
    end
    sent_count++;
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  function automatic stim_row_t record_row(int pass, int key, bit wr);
    stim_row_t row;
    row.it = '0;
    row.it.cmd = ptopo_pkg::CMD_RECORD;
    row.it.pass_index = 5'(pass);
    row.it.resource_key = 8'(key);
    row.it.is_write = wr;
    row.it.pass_count = 6'($urandom_range(63));
    row.typed = 1'b0;
    row.nexp = 0;
    return row;
  endfunction

  function automatic stim_row_t run_row(int n);
    stim_row_t row;
    row.it = '0;
    row.it.cmd = ptopo_pkg::CMD_RUN;
    row.it.pass_index = 5'($urandom_range(31));
    row.it.resource_key = 8'($urandom_range(255));
    row.it.is_write = 1'($urandom_range(1));
    row.it.pass_count = 6'(n);
    row.typed = 1'b0;
    row.nexp = 0;
    return row;
  endfunction

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    int n, recs, key_span;
    for (int k = 0; k < 256; k++) begin
      writer_mask[k] = '0;
      reader_mask[k] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    row = run_row(1);
    row.typed = 1'b1; row.nexp = 1; row.e0 = '{5'd0, 1'b0, 1'b1};
    table_rows = {table_rows, row};
    row = run_row(0);
    row.typed = 1'b1; row.nexp = 0;
    table_rows = {table_rows, row};
    table_rows = {table_rows, record_row(1, 5, 1'b1)};
    table_rows = {table_rows, record_row(0, 5, 1'b0)};
    table_rows = {table_rows, record_row(0, 200, 1'b1)};
    table_rows = {table_rows, record_row(1, 200, 1'b0)};
    row = run_row(2);
    row.typed = 1'b1; row.nexp = 2;
    row.e0 = '{5'd0, 1'b1, 1'b0};
    row.e1 = '{5'd1, 1'b1, 1'b1};
    table_rows = {table_rows, row};
    table_rows = {table_rows, record_row(31, 255, 1'b1)};
    table_rows = {table_rows, record_row(0, 255, 1'b0)};
    table_rows = {table_rows, record_row(0, 0, 1'b1)};
    table_rows = {table_rows, record_row(17, 0, 1'b0)};
    table_rows = {table_rows, run_row(63)};
    table_rows = {table_rows, record_row(5, 3, 1'b1)};
    table_rows = {table_rows, record_row(2, 3, 1'b0)};
    table_rows = {table_rows, record_row(0, 3, 1'b1)};
    table_rows = {table_rows, run_row(3)};
    table_rows = {table_rows, record_row(4, 9, 1'b1)};
    table_rows = {table_rows, record_row(4, 9, 1'b0)};
    table_rows = {table_rows, run_row(0)};
    table_rows = {table_rows, record_row(2, 7, 1'b0)};
    table_rows = {table_rows, record_row(3, 7, 1'b0)};
    table_rows = {table_rows, run_row(32)};
    table_rows = {table_rows, run_row(33)};
    foreach (table_rows[i]) send_item(table_rows[i]);

    while (sent_count < 480) begin
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(9))
          0: n = $urandom_range(63);
          1, 2: n = $urandom_range(32);
          default: n = $urandom_range(1, 8);
        endcase
        recs = $urandom_range(0, 12);
        key_span = ($urandom_range(3) == 0) ? 255 : 7;
        for (int j = 0; j < recs; j++) begin
          if (n > 0 && $urandom_range(9) != 0)
            send_item(record_row($urandom_range((n > 32 ? 32 : n) - 1),
                                 $urandom_range(key_span), 1'($urandom_range(1))));
          else
            send_item(record_row($urandom_range(31), $urandom_range(255),
                                 1'($urandom_range(1))));
        end
        send_item(run_row(n));
      end else begin
        row.it = ptopo_pkg::item_t'(21'($urandom()));
        row.typed = 1'b0;
        send_item(row);
      end
    end
    send_item(run_row($urandom_range(1, 8)));
    while (expected_order.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed && expected_order.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int cycle;
    cycle = 0;
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle >= 3000 && cycle < 5000)
        result_ready = 1'b0;
      else if (cycle >= 6000 && cycle < 9000)
        result_ready = 1'b1;
      else
        result_ready = ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    ptopo_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_order.size() == 0) begin
        $error("unexpected result transaction: %p", result);
        failed = 1'b1;
      end else begin
        want = expected_order.pop_front();
        if (result.order_pass !== want.order_pass) begin
          $error("order_pass expected %0d actual %0d", want.order_pass, result.order_pass);
          failed = 1'b1;
        end
        if (result.cycle_detected !== want.cycle_detected) begin
          $error("cycle_detected expected %0b actual %0b",
                 want.cycle_detected, result.cycle_detected);
          failed = 1'b1;
        end
        if (result.last !== want.last) begin
          $error("last expected %0b actual %0b", want.last, result.last);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
